// ===== hw/rtl/etf_pkg.sv =====
package etf_pkg;

    // Word format of the fixed-point datapath
    localparam int WORD_BITS     = 32;
    localparam int FRACTION_BITS = 26;

    // Fixed field widths of the ports
    localparam int POINT_W  = 32;
    localparam int MODE_W   = 2;
    localparam int COUNT_W  = 16;
    localparam int LIMIT_W  = 31;
    localparam int CFG_W    = 31;
    localparam int CFG_IDX_W = 1;

    // Derived widths
    localparam int PROD_W = 2 * WORD_BITS;
    localparam int EXT_W  = ((WORD_BITS > POINT_W) ? WORD_BITS : POINT_W) + 2;
    localparam int SUM_W  = PROD_W + 1;
    localparam int CMP_W  = ((SUM_W - FRACTION_BITS) > LIMIT_W) ?
                            (SUM_W - FRACTION_BITS) : LIMIT_W;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [PROD_W-1:0]    t_prod;
    typedef logic signed [EXT_W-1:0]     t_ext;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_LIMIT  = 1'd1;

    // Fractal kinds
    localparam logic [MODE_W-1:0] MODE_CUBIC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRICORN = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SHIP    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPIDER  = 2'd3;

    // Reset values of the registers
    localparam logic [COUNT_W-1:0] MAX_ITER_RESET  = 16'd100;
    localparam logic [LIMIT_W-1:0] ESC_LIMIT_RESET = 31'd268435456;

    // Word limits
    localparam t_word WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // Constants 0.05 and 0.01, rounded to nearest
    localparam logic [63:0] K005_RAW = ((64'd5 << FRACTION_BITS) + 64'd50) / 64'd100;
    localparam logic [63:0] K001_RAW = ((64'd1 << FRACTION_BITS) + 64'd50) / 64'd100;
    localparam t_word K005 = t_word'(K005_RAW);
    localparam t_word K001 = t_word'(K001_RAW);

    // Clamp an extended value to the word range
    function automatic t_word f_clamp(input t_ext v);
        t_ext hi;
        t_ext lo;
        hi = t_ext'(WORD_MAX);
        lo = t_ext'(WORD_MIN);
        if (v > hi) begin
            return WORD_MAX;
        end else if (v < lo) begin
            return WORD_MIN;
        end else begin
            return t_word'(v);
        end
    endfunction

    // Saturating add and subtract
    function automatic t_word f_add(input t_word a, input t_word b);
        return f_clamp(t_ext'(a) + t_ext'(b));
    endfunction

    function automatic t_word f_sub(input t_word a, input t_word b);
        return f_clamp(t_ext'(a) - t_ext'(b));
    endfunction

    // Saturating absolute value
    function automatic t_word f_abs(input t_word a);
        if (a < 0) begin
            return f_clamp(-t_ext'(a));
        end
        return a;
    endfunction

    // Point field into the word format
    function automatic t_word f_load(input logic signed [POINT_W-1:0] v);
        return f_clamp(t_ext'(v));
    endfunction

    // Product back to word scale: floor shift, then saturate
    function automatic t_word f_scale(input t_prod p);
        t_prod q;
        t_prod hi;
        t_prod lo;
        q  = p >>> FRACTION_BITS;
        hi = t_prod'(WORD_MAX);
        lo = t_prod'(WORD_MIN);
        if (q > hi) begin
            return WORD_MAX;
        end else if (q < lo) begin
            return WORD_MIN;
        end else begin
            return t_word'(q);
        end
    endfunction

    // Control of the escape unit
    typedef struct packed {
        logic load_sq;
        logic eval;
    } t_esc_ctl;

endpackage

// ===== hw/rtl/etf_mul.sv =====
module etf_mul
    import etf_pkg::*;
(
    input  logic  i_clk,
    input  t_word i_a,
    input  t_word i_b,
    output t_prod o_prod
);

    // Shared signed multiplier, full product registered
    t_prod r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= t_prod'(i_a) * t_prod'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== hw/rtl/etf_escape.sv =====
module etf_escape
    import etf_pkg::*;
(
    input  logic               i_clk,
    input  t_esc_ctl           i_ctl,
    input  t_prod              i_prod,
    input  logic [LIMIT_W-1:0] i_limit,
    output logic               o_escaped
);

    logic [PROD_W-1:0] r_sq;
    logic              r_escaped;
    logic [SUM_W-1:0]  n_sum;
    logic [CMP_W-1:0]  n_mag;

    // Exact x^2 + y^2, scaled down, against the threshold
    always_comb begin
        n_sum = {1'b0, r_sq} + {1'b0, i_prod};
        n_mag = CMP_W'(n_sum >> FRACTION_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_sq) begin
            r_sq <= i_prod;
        end
        if (i_ctl.eval) begin
            r_escaped <= n_mag > CMP_W'(i_limit);
        end
    end

    assign o_escaped = r_escaped;

endmodule

// ===== hw/rtl/escape_time_fractal_iterator.sv =====
// Escape-time iteration counter for one point at a time.
//
// Command channel: present i_mode, i_point_re and i_point_im with start high;
// the transfer happens on a rising edge where start is high and busy is low.
// busy then stays high until the count is ready.
// Result channel: o_result_valid is high for exactly one cycle with
// o_iteration_count; the receiver must take it then, it cannot stall.
// A new command may be given in the cycle the result is shown.
// Configuration: i_cfg_wr_en writes i_cfg_wdata into register i_cfg_index
// (0: iteration cap, 1: escape threshold) at once; write only while idle.
// Sequence: one shared multiplier does every product. An iteration steps
// through the states X2, Y2, XY and P (tricorn, burning ship, spider), the
// cubic kind adding MX, MY and MZ; the spider mode first passes through the
// set-up states C0, C1 and C2. A run ends when the count reaches the cap,
// or sooner on an escape.
// Reset (synchronous, active low) returns the sequencer to idle, drops
// o_result_valid and restores the cap to 100 and the threshold to 2^28.
module escape_time_fractal_iterator
    import etf_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [MODE_W-1:0]         i_mode,
    input  logic signed [POINT_W-1:0] i_point_re,
    input  logic signed [POINT_W-1:0] i_point_im,
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_wdata,
    output logic                      o_result_valid,
    output logic [COUNT_W-1:0]        o_iteration_count
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_C0,
        ST_C1,
        ST_C2,
        ST_X2,
        ST_Y2,
        ST_XY,
        ST_P,
        ST_MX,
        ST_MY,
        ST_MZ
    } t_state;

    t_state             r_state;
    logic [MODE_W-1:0]  r_mode;
    t_word              r_zr;
    t_word              r_zi;
    t_word              r_cr;
    t_word              r_ci;
    t_word              r_x2;
    t_word              r_y2;
    t_word              r_t1;
    t_word              r_t2;
    logic [COUNT_W-1:0] r_cnt;
    logic [COUNT_W-1:0] r_max;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_valid;
    logic [COUNT_W-1:0] r_count_out;

    t_word    n_mul_a;
    t_word    n_mul_b;
    t_prod    mul_prod;
    t_word    n_prod_w;
    t_esc_ctl n_esc_ctl;
    logic     esc_flag;
    t_word    n_pr;
    t_word    n_pi;
    t_word    n_diff;
    t_word    n_nx;
    t_word    n_ny;
    t_word    n_pp;
    t_word    n_abs;
    t_word    n_t1;
    t_word    n_t2;
    t_word    n_cr3;
    t_word    n_ci3;

    // Operand selection for the shared multiplier
    always_comb begin
        n_mul_a = r_zr;
        n_mul_b = r_zr;
        case (r_state)
            ST_C0: begin
                n_mul_a = r_cr;
                n_mul_b = K001;
            end
            ST_C1: begin
                n_mul_a = r_ci;
                n_mul_b = K001;
            end
            ST_X2: begin
                n_mul_a = r_zr;
                n_mul_b = r_zr;
            end
            ST_Y2: begin
                n_mul_a = r_zi;
                n_mul_b = r_zi;
            end
            ST_XY: begin
                n_mul_a = r_zr;
                n_mul_b = r_zi;
            end
            ST_MX: begin
                n_mul_a = r_zr;
                n_mul_b = r_t1;
            end
            ST_MY: begin
                n_mul_a = r_zi;
                n_mul_b = r_t2;
            end
            default: begin
                n_mul_a = r_zr;
                n_mul_b = r_zr;
            end
        endcase
    end

    etf_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (n_mul_a),
        .i_b    (n_mul_b),
        .o_prod (mul_prod)
    );

    // Escape unit: x^2 kept in Y2, compared with y^2 added in XY
    always_comb begin
        n_esc_ctl.load_sq = (r_state == ST_Y2);
        n_esc_ctl.eval    = (r_state == ST_XY);
    end

    etf_escape u_escape (
        .i_clk     (i_clk),
        .i_ctl     (n_esc_ctl),
        .i_prod    (mul_prod),
        .i_limit   (r_limit),
        .o_escaped (esc_flag)
    );

    // Update arithmetic of one iteration
    always_comb begin
        n_prod_w = f_scale(mul_prod);
        n_pr     = f_load(i_point_re);
        n_pi     = f_load(i_point_im);
        n_diff   = f_sub(r_x2, r_y2);
        n_nx     = f_add(n_diff, r_cr);
        n_pp     = f_add(n_prod_w, n_prod_w);
        n_abs    = f_abs(n_prod_w);
        case (r_mode)
            MODE_TRICORN: n_ny = f_sub(r_ci, n_pp);
            MODE_SHIP:    n_ny = f_add(f_add(n_abs, n_abs), r_ci);
            default:      n_ny = f_add(n_pp, r_ci);
        endcase
        n_cr3 = f_add(r_cr >>> 1, n_nx);
        n_ci3 = f_add(r_ci >>> 1, n_ny);
        n_t1  = f_sub(r_x2, f_add(f_add(r_y2, r_y2), r_y2));
        n_t2  = f_sub(f_add(f_add(r_x2, r_x2), r_x2), r_y2);
    end

    // Sequencer, datapath registers and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_cnt   <= '0;
            r_max   <= MAX_ITER_RESET;
            r_limit <= ESC_LIMIT_RESET;
        end else begin
            r_valid <= 1'b0;

            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_MAX_ITER:  r_max   <= i_cfg_wdata[COUNT_W-1:0];
                    REG_ESC_LIMIT: r_limit <= i_cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_mode <= i_mode;
                        r_cnt  <= '0;
                        r_zr   <= '0;
                        r_zi   <= '0;
                        case (i_mode)
                            MODE_SHIP: begin
                                r_cr    <= f_sub(n_pr, K005);
                                r_ci    <= f_sub(n_pi, K005);
                                r_state <= ST_X2;
                            end
                            MODE_SPIDER: begin
                                r_cr    <= n_pr;
                                r_ci    <= n_pi;
                                r_state <= ST_C0;
                            end
                            default: begin
                                r_cr    <= n_pr;
                                r_ci    <= n_pi;
                                r_state <= ST_X2;
                            end
                        endcase
                    end
                end
                ST_C0: begin
                    r_state <= ST_C1;
                end
                ST_C1: begin
                    r_cr    <= n_prod_w;
                    r_zr    <= n_prod_w;
                    r_state <= ST_C2;
                end
                ST_C2: begin
                    r_ci    <= n_prod_w;
                    r_zi    <= n_prod_w;
                    r_state <= ST_X2;
                end
                // Loop head: stop at the cap
                ST_X2: begin
                    if (r_cnt >= r_max) begin
                        r_count_out <= r_cnt;
                        r_valid     <= 1'b1;
                        r_state     <= ST_IDLE;
                    end else begin
                        r_state <= ST_Y2;
                    end
                end
                ST_Y2: begin
                    r_x2    <= n_prod_w;
                    r_state <= ST_XY;
                end
                ST_XY: begin
                    r_y2    <= n_prod_w;
                    r_state <= ST_P;
                end
                // Escape decision and update; spider tests the z made last pass
                ST_P: begin
                    if (r_mode == MODE_SPIDER && esc_flag && r_cnt != '0) begin
                        r_count_out <= r_cnt;
                        r_valid     <= 1'b1;
                        r_state     <= ST_IDLE;
                    end else if (r_mode != MODE_SPIDER && esc_flag) begin
                        r_count_out <= r_cnt + 1'b1;
                        r_valid     <= 1'b1;
                        r_state     <= ST_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                        case (r_mode)
                            MODE_CUBIC: begin
                                r_t1    <= n_t1;
                                r_t2    <= n_t2;
                                r_state <= ST_MX;
                            end
                            MODE_SPIDER: begin
                                r_zr    <= n_nx;
                                r_zi    <= n_ny;
                                r_cr    <= n_cr3;
                                r_ci    <= n_ci3;
                                r_state <= ST_X2;
                            end
                            default: begin
                                r_zr    <= n_nx;
                                r_zi    <= n_ny;
                                r_state <= ST_X2;
                            end
                        endcase
                    end
                end
                ST_MX: begin
                    r_state <= ST_MY;
                end
                ST_MY: begin
                    r_zr    <= f_add(n_prod_w, r_cr);
                    r_state <= ST_MZ;
                end
                ST_MZ: begin
                    r_zi    <= f_add(n_prod_w, r_ci);
                    r_state <= ST_X2;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy              = (r_state != ST_IDLE);
    assign o_result_valid    = r_valid;
    assign o_iteration_count = r_count_out;

    // A command transfer always starts a run
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command taken but sequencer stayed idle");

    // A result only ends a run and leaves the block idle
    a_result_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(busy) && !busy))
        else $error("result strobe without a finished run");

    // Result strobe lasts one cycle
    a_result_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

endmodule

// ===== test/tb_escape_time_fractal_iterator.sv =====
`timescale 1ns / 100ps

module tb_escape_time_fractal_iterator;
    import etf_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 6_000_000;
    localparam int          ITEMS_PER_PHASE = 250;
    localparam int          RANDOM_PHASES   = 5;
    localparam int          SETTLE_CYCLES   = 8;

    // Word bounds and rounded constants in the predictor's 64-bit arithmetic
    localparam longint W_HI  = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
    localparam longint W_LO  = -W_HI - 64'sd1;
    localparam longint K_005 = ((64'sd5 <<< FRACTION_BITS) + 64'sd50) / 64'sd100;
    localparam longint K_001 = ((64'sd1 <<< FRACTION_BITS) + 64'sd50) / 64'sd100;

    localparam logic signed [POINT_W-1:0] P_MAX   = {1'b0, {(POINT_W-1){1'b1}}};
    localparam logic signed [POINT_W-1:0] P_MIN   = {1'b1, {(POINT_W-1){1'b0}}};
    localparam logic signed [POINT_W-1:0] QUARTER = 32'sh0100_0000;

    localparam logic [MODE_W-1:0] MODES [4] = '{MODE_CUBIC, MODE_TRICORN, MODE_SHIP,
                                                MODE_SPIDER};

    // Predicts the iteration count of each accepted point and checks results in order
    class iter_count_board;
        bit [COUNT_W-1:0] cap;
        bit [LIMIT_W-1:0] esc_limit;
        longint           z_re, z_im, c_re, c_im;
        int unsigned      iter_cnt;
        bit [COUNT_W-1:0] pending_counts[$];
        int unsigned      counts_checked;
        int unsigned      errors;

        function new();
            cap            = MAX_ITER_RESET;
            esc_limit      = ESC_LIMIT_RESET;
            z_re           = 0;
            z_im           = 0;
            c_re           = 0;
            c_im           = 0;
            iter_cnt       = 0;
            counts_checked = 0;
            errors         = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_MAX_ITER:  cap       = data[COUNT_W-1:0];
                REG_ESC_LIMIT: esc_limit = data[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clip(longint v);
            if (v > W_HI) return W_HI;
            if (v < W_LO) return W_LO;
            return v;
        endfunction

        function longint sat_add(longint a, longint b);
            return clip(a + b);
        endfunction

        function longint sat_sub(longint a, longint b);
            return clip(a - b);
        endfunction

        // exact product, floor shift back to word scale, then saturate
        function longint fx_mul(longint a, longint b);
            return clip((a * b) >>> FRACTION_BITS);
        endfunction

        // squared magnitude kept exact, no saturation
        function bit escapes(longint x, longint y);
            logic [64:0] sq;
            sq = 65'(x * x) + 65'(y * y);
            return (sq >> FRACTION_BITS) > 65'(esc_limit);
        endfunction

        function bit [COUNT_W-1:0] count_for(logic [MODE_W-1:0] mode, longint pr,
                                             longint pi);
            longint x, y, x2, y2, xy, t, nx, ny;
            case (mode)
                MODE_SHIP: begin
                    c_re = sat_sub(pr, K_005);
                    c_im = sat_sub(pi, K_005);
                end
                MODE_SPIDER: begin
                    c_re = fx_mul(pr, K_001);
                    c_im = fx_mul(pi, K_001);
                end
                default: begin
                    c_re = pr;
                    c_im = pi;
                end
            endcase
            z_re     = (mode == MODE_SPIDER) ? c_re : 0;
            z_im     = (mode == MODE_SPIDER) ? c_im : 0;
            iter_cnt = 0;
            while (iter_cnt < cap) begin
                x  = z_re;
                y  = z_im;
                x2 = fx_mul(x, x);
                y2 = fx_mul(y, y);
                xy = fx_mul(x, y);
                case (mode)
                    MODE_CUBIC: begin
                        t  = sat_sub(x2, sat_add(sat_add(y2, y2), y2));
                        nx = sat_add(fx_mul(x, t), c_re);
                        t  = sat_sub(sat_add(sat_add(x2, x2), x2), y2);
                        ny = sat_add(fx_mul(y, t), c_im);
                    end
                    MODE_TRICORN: begin
                        nx = sat_add(sat_sub(x2, y2), c_re);
                        ny = sat_sub(c_im, sat_add(xy, xy));
                    end
                    MODE_SHIP: begin
                        t  = (xy < 0) ? clip(-xy) : xy;
                        nx = sat_add(sat_sub(x2, y2), c_re);
                        ny = sat_add(sat_add(t, t), c_im);
                    end
                    default: begin
                        // spider: c drifts towards the new z, floor halving
                        nx   = sat_add(sat_sub(x2, y2), c_re);
                        ny   = sat_add(sat_add(xy, xy), c_im);
                        c_re = sat_add(c_re >>> 1, nx);
                        c_im = sat_add(c_im >>> 1, ny);
                    end
                endcase
                z_re = nx;
                z_im = ny;
                iter_cnt++;
                // spider tests the new z, the others the z from before
                if ((mode == MODE_SPIDER) ? escapes(nx, ny) : escapes(x, y)) break;
            end
            return iter_cnt[COUNT_W-1:0];
        endfunction

        function void note_command(logic [MODE_W-1:0] mode, logic signed [POINT_W-1:0] re,
                                   logic signed [POINT_W-1:0] im);
            pending_counts.push_back(count_for(mode, clip(longint'(re)), clip(longint'(im))));
        endfunction

        function void check_count(logic [COUNT_W-1:0] got);
            bit [COUNT_W-1:0] want;
            if (pending_counts.size() == 0) begin
                $error("iteration_count: result with nothing expected, actual %0d", got);
                errors++;
                return;
            end
            want = pending_counts.pop_front();
            counts_checked++;
            if (got !== want) begin
                $error("iteration_count: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      start       = 1'b0;
    logic                      busy;
    logic [MODE_W-1:0]         i_mode      = MODE_CUBIC;
    logic signed [POINT_W-1:0] i_point_re  = '0;
    logic signed [POINT_W-1:0] i_point_im  = '0;
    logic                      i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = REG_MAX_ITER;
    logic [CFG_W-1:0]          i_cfg_wdata = '0;
    logic                      o_result_valid;
    logic [COUNT_W-1:0]        o_iteration_count;

    iter_count_board board;
    int unsigned     points_sent;
    int unsigned     settings_used;

    escape_time_fractal_iterator u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_mode            (i_mode),
        .i_point_re        (i_point_re),
        .i_point_im        (i_point_im),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_result_valid    (o_result_valid),
        .o_iteration_count (o_iteration_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Results cannot be held off: check every strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1) begin
            board.check_count(o_iteration_count);
        end
    end

    // Mostly the region around the sets, some full range, some extremes
    function automatic logic signed [POINT_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
            5:             return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
            6, 7:          return $urandom;
            8: begin
                case ($urandom_range(0, 4))
                    0:       return P_MAX;
                    1:       return P_MIN;
                    2:       return '0;
                    3:       return -1;
                    default: return 1;
                endcase
            end
            default:       return $urandom_range(0, 2048) - 1024;
        endcase
    endfunction

    // Both registers, back to back, block idle
    task automatic set_config(input logic [COUNT_W-1:0] cap, input logic [LIMIT_W-1:0] lim);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_MAX_ITER;
        i_cfg_wdata <= CFG_W'(cap);
        board.set_register(REG_MAX_ITER, CFG_W'(cap));
        @(posedge i_clk);
        i_cfg_index <= REG_ESC_LIMIT;
        i_cfg_wdata <= CFG_W'(lim);
        board.set_register(REG_ESC_LIMIT, CFG_W'(lim));
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    // One command transfer; start stays high afterwards so the next may follow at once
    task automatic send_point(input logic [MODE_W-1:0] mode,
                              input logic signed [POINT_W-1:0] re,
                              input logic signed [POINT_W-1:0] im, input bit idling);
        if (idling && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_mode     <= mode;
        i_point_re <= re;
        i_point_im <= im;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        board.note_command(mode, re, im);
        points_sent++;
    endtask

    // Drop start and wait for every outstanding count
    task automatic finish_burst();
        start <= 1'b0;
        while (board.pending_counts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        board         = new();
        points_sent   = 0;
        settings_used = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: each kind at zero, corners and a point inside the set
        foreach (MODES[m]) begin
            send_point(MODES[m], '0, '0, 1'b1);
            send_point(MODES[m], P_MAX, P_MIN, 1'b1);
            send_point(MODES[m], P_MIN, P_MAX, 1'b1);
            send_point(MODES[m], -QUARTER, QUARTER, 1'b1);
        end
        // offset saturating at the bottom, and the smallest steps
        send_point(MODE_SHIP, P_MIN, P_MIN, 1'b1);
        send_point(MODE_CUBIC, 1, -1, 1'b1);
        finish_burst();

        // Zero cap: no iteration at all
        set_config('0, ESC_LIMIT_RESET);
        foreach (MODES[m]) send_point(MODES[m], QUARTER, -QUARTER, 1'b1);
        finish_burst();

        // Full cap with a zero threshold: origin never escapes, the rest at once
        set_config('1, '0);
        send_point(MODE_TRICORN, '0, '0, 1'b1);
        send_point(MODE_CUBIC, P_MAX, P_MAX, 1'b1);
        send_point(MODE_SHIP, P_MIN, P_MAX, 1'b1);
        send_point(MODE_SPIDER, P_MAX, P_MIN, 1'b1);
        finish_burst();

        // Random points over several settings; the last phase runs without gaps
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: set_config(MAX_ITER_RESET, ESC_LIMIT_RESET);
                1: set_config(MAX_ITER_RESET, '1);
                2: set_config(COUNT_W'($urandom_range(1, 60)), LIMIT_W'($urandom));
                3: set_config(COUNT_W'($urandom_range(0, 12)),
                              LIMIT_W'($urandom_range(0, 32'h1000_0000)));
                default: set_config(MAX_ITER_RESET, ESC_LIMIT_RESET);
            endcase
            repeat (ITEMS_PER_PHASE) begin
                send_point(MODES[$urandom_range(0, 3)], pick_coord(), pick_coord(),
                           phase != RANDOM_PHASES - 1);
            end
            finish_burst();
        end

        $display("Sent %0d points of all four kinds over %0d register settings (cap 0 to 65535).",
                 points_sent, settings_used);
        $display("Checked %0d iteration counts, %0d errors.", board.counts_checked,
                 board.errors);
        if (board.errors == 0) begin
            $display("escape_time_fractal_iterator: match");
        end else begin
            $display("escape_time_fractal_iterator: mismatch");
        end
        $finish;
    end

    // Watchdog
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("escape_time_fractal_iterator: mismatch");
        $finish;
    end

endmodule
